// File: sv/rmh_pkg.sv
// Shared types and constants for the running median block.
package rmh_pkg;

  localparam int SAMPLE_PORT_W = 32;
  localparam int MEDIAN_W      = 33;
  localparam int COUNT_W       = 11;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PUSH,
    OP_UP_RD,
    OP_UP_CMP,
    OP_POP,
    OP_DN_LAST,
    OP_DN_RD,
    OP_DN_CMP,
    OP_MOVE,
    OP_FIN
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic up_root;
    logic up_swap;
    logic dn_empty;
    logic dn_move;
    logic need_pop_lower;
    logic need_pop_upper;
  } stat_t;

endpackage

// File: sv/rmh_mem.sv
// Heap storage: one write port, two registered read ports.
module rmh_mem #(
  parameter int DEPTH = 513,
  parameter int AW    = 10,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [DW-1:0] rdata0,
  output logic [DW-1:0] rdata1
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// File: sv/rmh_ctrl.sv
// Sequencer for insert, rebalance and result transfer.
module rmh_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  rmh_pkg::stat_t st,
  output rmh_pkg::cmd_t  cmd
);
  import rmh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH, S_UP_RD, S_UP_CMP, S_BAL, S_POP, S_DN_LAST,
    S_DN_RD, S_DN_CMP, S_MOVE, S_FIN, S_OUT
  } state_t;

  state_t state;
  logic   moved;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      moved <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          moved <= 1'b0;
          if (in_valid) begin
            state <= st.full ? S_FIN : S_PUSH;
          end
        end
        S_PUSH:  state <= S_UP_RD;
        S_UP_RD: begin
          if (st.up_root) begin
            state <= moved ? S_FIN : S_BAL;
          end else begin
            state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (st.up_swap) begin
            state <= S_UP_RD;
          end else begin
            state <= moved ? S_FIN : S_BAL;
          end
        end
        S_BAL: begin
          state <= (st.need_pop_lower || st.need_pop_upper) ? S_POP : S_FIN;
        end
        S_POP:     state <= S_DN_LAST;
        S_DN_LAST: state <= st.dn_empty ? S_MOVE : S_DN_RD;
        S_DN_RD:   state <= S_DN_CMP;
        S_DN_CMP:  state <= st.dn_move ? S_DN_RD : S_MOVE;
        S_MOVE: begin
          moved <= 1'b1;
          state <= S_UP_RD;
        end
        S_FIN: state <= S_OUT;
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    case (state)
      S_IDLE:    cmd.op = OP_LOAD;
      S_PUSH:    cmd.op = OP_PUSH;
      S_UP_RD:   cmd.op = OP_UP_RD;
      S_UP_CMP:  cmd.op = OP_UP_CMP;
      S_POP:     cmd.op = OP_POP;
      S_DN_LAST: cmd.op = OP_DN_LAST;
      S_DN_RD:   cmd.op = OP_DN_RD;
      S_DN_CMP:  cmd.op = OP_DN_CMP;
      S_MOVE:    cmd.op = OP_MOVE;
      S_FIN:     cmd.op = OP_FIN;
      default:   cmd.op = OP_NONE;
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

endmodule

// File: sv/rmh_dp.sv
// Datapath: two heaps, their sizes, sift registers and result registers.
module rmh_dp #(
  parameter int CAPACITY     = 1024,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rmh_pkg::cmd_t                       cmd,
  output rmh_pkg::stat_t                      st,
  input  logic [rmh_pkg::SAMPLE_PORT_W-1:0]   sample,
  output logic signed [rmh_pkg::MEDIAN_W-1:0] median_doubled,
  output logic [rmh_pkg::COUNT_W-1:0]         stored_count,
  output logic                                rejected
);
  import rmh_pkg::*;

  localparam int DEPTH = CAPACITY / 2 + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(DEPTH + 1);

  logic [SW-1:0] lsize, usize, cnt;
  logic [AW-1:0] idx;
  logic          sel, rej;
  logic signed [SAMPLE_WIDTH-1:0] x, val, popped, lo_top, up_top;

  logic [SAMPLE_WIDTH-1:0] l_rd0, l_rd1, u_rd0, u_rd1;
  logic signed [SAMPLE_WIDTH-1:0] rd0, rd1, wdata, best_val;
  logic [AW-1:0] raddr0, raddr1, waddr, parent, laddr, raddr, best_idx;
  logic          we, psel, lvalid, rvalid, to_lower;
  logic [SW:0]   lw, rw, psize;
  logic [31:0]   total;

  function automatic logic above(input logic signed [SAMPLE_WIDTH-1:0] a,
                                 input logic signed [SAMPLE_WIDTH-1:0] b,
                                 input logic s);
    return s ? (a < b) : (a > b);
  endfunction

  assign rd0      = $signed(sel ? u_rd0 : l_rd0);
  assign rd1      = $signed(sel ? u_rd1 : l_rd1);
  assign parent   = AW'((idx - 1'b1) >> 1);
  assign lw       = (SW + 1)'({idx, 1'b1});
  assign rw       = lw + 1'b1;
  assign lvalid   = lw < (SW + 1)'(cnt);
  assign rvalid   = rw < (SW + 1)'(cnt);
  assign laddr    = lvalid ? lw[AW-1:0] : '0;
  assign raddr    = rvalid ? rw[AW-1:0] : '0;
  assign psel     = !st.need_pop_lower;
  assign psize    = (SW + 1)'(psel ? usize : lsize);
  assign to_lower = (lsize == '0) || (x <= lo_top);
  assign total    = 32'(lsize) + 32'(usize);

  always_comb begin
    best_idx = idx;
    best_val = val;
    if (lvalid && above(rd0, best_val, sel)) begin
      best_idx = laddr;
      best_val = rd0;
    end
    if (rvalid && above(rd1, best_val, sel)) begin
      best_idx = raddr;
      best_val = rd1;
    end
  end

  assign st.full           = total >= 32'(CAPACITY);
  assign st.up_root        = (idx == '0);
  assign st.up_swap        = above(val, rd0, sel);
  assign st.dn_empty       = (cnt == '0);
  assign st.dn_move        = (best_idx != idx);
  assign st.need_pop_lower = (SW + 1)'(lsize) > (SW + 1)'(usize) + 1'b1;
  assign st.need_pop_upper = usize > lsize;

  always_comb begin
    raddr0 = parent;
    raddr1 = raddr;
    we     = 1'b0;
    waddr  = idx;
    wdata  = val;
    case (cmd.op)
      OP_POP:    raddr0 = AW'(psize - 1'b1);
      OP_DN_RD:  raddr0 = laddr;
      OP_UP_RD:  we = st.up_root;
      OP_UP_CMP: begin
        we    = 1'b1;
        wdata = st.up_swap ? rd0 : val;
      end
      OP_DN_CMP: begin
        we    = 1'b1;
        wdata = best_val;
      end
      default: ;
    endcase
  end

  rmh_mem #(.DEPTH(DEPTH), .AW(AW), .DW(SAMPLE_WIDTH)) u_lower (
    .clk(clk), .we(we && !sel), .waddr(waddr), .wdata(wdata),
    .raddr0(raddr0), .raddr1(raddr1), .rdata0(l_rd0), .rdata1(l_rd1)
  );

  rmh_mem #(.DEPTH(DEPTH), .AW(AW), .DW(SAMPLE_WIDTH)) u_upper (
    .clk(clk), .we(we && sel), .waddr(waddr), .wdata(wdata),
    .raddr0(raddr0), .raddr1(raddr1), .rdata0(u_rd0), .rdata1(u_rd1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lsize <= '0;
      usize <= '0;
    end else begin
      case (cmd.op)
        OP_PUSH: begin
          if (to_lower) lsize <= lsize + 1'b1;
          else          usize <= usize + 1'b1;
        end
        OP_POP: begin
          if (psel) usize <= usize - 1'b1;
          else      lsize <= lsize - 1'b1;
        end
        OP_MOVE: begin
          if (sel) lsize <= lsize + 1'b1;
          else     usize <= usize + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we && waddr == '0) begin
      if (sel) up_top <= wdata;
      else     lo_top <= wdata;
    end
    case (cmd.op)
      OP_LOAD: begin
        x   <= $signed(sample[SAMPLE_WIDTH-1:0]);
        rej <= st.full;
      end
      OP_PUSH: begin
        sel <= !to_lower;
        val <= x;
        idx <= AW'(to_lower ? lsize : usize);
      end
      OP_UP_CMP: if (st.up_swap) idx <= parent;
      OP_POP: begin
        sel    <= psel;
        popped <= psel ? up_top : lo_top;
        cnt    <= SW'(psize - 1'b1);
      end
      OP_DN_LAST: begin
        val <= rd0;
        idx <= '0;
      end
      OP_DN_CMP: idx <= best_idx;
      OP_MOVE: begin
        sel <= !sel;
        val <= popped;
        idx <= AW'(sel ? lsize : usize);
      end
      OP_FIN: begin
        rejected     <= rej;
        stored_count <= total[COUNT_W-1:0];
        if (lsize == usize) begin
          median_doubled <= MEDIAN_W'(lo_top) + MEDIAN_W'(up_top);
        end else begin
          median_doubled <= MEDIAN_W'(lo_top) <<< 1;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: sv/running_median_two_heaps.sv
// Running median over two heaps: one signed sample in, one median result out.
// Input channel: in_valid/in_stall with sample; a transfer happens when
// in_valid is high and in_stall is low. The block holds in_stall high from
// the transfer until its result has been taken.
// Output channel: out_valid/out_stall with median_doubled (twice the median,
// the sum of both heap tops for an even count), stored_count and rejected.
// Each sample is pushed into one heap and sifted up; a move between heaps adds
// a sift down and a second sift up, with one heap memory access (read, then
// compare and write) per heap level sifted.
// A sample arriving with CAPACITY samples held is dropped: rejected is set
// and the median is unchanged.
// Reset clears the heap sizes and the sequencer; heap memory is not cleared.
// While out_stall is high the result holds and no new sample is taken.
module running_median_two_heaps #(
  parameter int CAPACITY     = 1024,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rmh_pkg::SAMPLE_PORT_W-1:0]   sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rmh_pkg::MEDIAN_W-1:0] median_doubled,
  output logic [rmh_pkg::COUNT_W-1:0]         stored_count,
  output logic                                rejected
);
  import rmh_pkg::*;

  cmd_t  cmd;
  stat_t st;

  rmh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .st(st), .cmd(cmd)
  );

  rmh_dp #(.CAPACITY(CAPACITY), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st), .sample(sample),
    .median_doubled(median_doubled), .stored_count(stored_count),
    .rejected(rejected)
  );

  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid) else $error("result shown while idle");

  a_balanced: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!st.need_pop_lower && !st.need_pop_upper))
    else $error("heaps unbalanced at result");

  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rejected) |-> st.full) else $error("reject while not full");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (stored_count != '0 || CAPACITY > 2047))
    else $error("empty store at result");

endmodule

// File: verif/running_median_two_heaps_tb.sv
// Self-checking testbench for the two-heap running median block.
module running_median_two_heaps_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmh_pkg::*;

  localparam int CAP = 1024;
  localparam int LIMIT = 4_000_000;

  typedef struct {
    logic signed [MEDIAN_W-1:0] median;
    logic [COUNT_W-1:0]         count;
    logic                       rej;
  } median_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SAMPLE_PORT_W-1:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [MEDIAN_W-1:0] median_doubled;
  logic [COUNT_W-1:0] stored_count;
  logic rejected;

  median_res_t median_q[$];
  // sorted copy of the held samples
  longint held[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_rej = 0;
  longint cycles = 0;

  running_median_two_heaps u_top (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stall: long hold-off takes precedence over random stalls
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off  <= hold_off - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    median_res_t e;
    if (!rst && out_valid && !out_stall) begin
      n_checked <= n_checked + 1;
      if (median_q.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("Unexpected transfer: median %0d", median_doubled);
      end else begin
        e = median_q.pop_front();
        if (e.median !== median_doubled || e.count !== stored_count
            || e.rej !== rejected) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("Mismatch: exp m=%0d c=%0d r=%0b got m=%0d c=%0d r=%0b",
                     e.median, e.count, e.rej, median_doubled, stored_count, rejected);
        end
      end
    end
  end

  function automatic median_res_t predict_median(logic [SAMPLE_PORT_W-1:0] s);
    median_res_t r;
    longint x;
    int pos;
    int n;
    x = longint'(signed'(s));
    r.rej = 1'b0;
    if (held.size() >= CAP) begin
      r.rej = 1'b1;
    end else begin
      pos = 0;
      while (pos < held.size() && held[pos] <= x) pos++;
      held.insert(pos, x);
    end
    n = held.size();
    if (n % 2 == 1) r.median = MEDIAN_W'(2 * held[n/2]);
    else r.median = MEDIAN_W'(held[n/2 - 1] + held[n/2]);
    r.count = COUNT_W'(n);
    return r;
  endfunction

  // valid stays high after a transfer until the next idle cycle or drain
  task automatic send_sample(logic [SAMPLE_PORT_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    median_q.push_back(predict_median(s));
    n_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_PORT_W-1:0] rand_sample();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return SAMPLE_PORT_W'($urandom_range(20)) - 10;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_extremes;
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h8000_0000);
    send_sample(32'h8000_0000);
    send_sample('0);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0001);
    send_sample(32'h5555_5555);
    send_sample(32'hAAAA_AAAA);
    for (int i = 0; i < 8; i++) send_sample(SAMPLE_PORT_W'(i));
    for (int i = 0; i < 6; i++) send_sample(-SAMPLE_PORT_W'(i));
    drain();
  endtask

  task automatic test_random(int n, int idle, int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) send_sample(rand_sample());
    drain();
  endtask

  task automatic test_backpressure;
    hold_off = 400;
    for (int i = 0; i < 20; i++) send_sample(rand_sample());
    drain();
  endtask

  task automatic test_store_full;
    send_idle_pct  = 0;
    recv_stall_pct = 20;
    while (held.size() < CAP) send_sample(rand_sample());
    for (int i = 0; i < 40; i++) begin
      send_sample(rand_sample());
      if (median_q[$].rej) n_rej++;
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_random(150, 0, 0);
    test_backpressure();
    test_random(150, 88, 0);
    test_random(150, 0, 88);
    test_random(150, 38, 38);
    test_store_full();
    test_random(700, 38, 38);
    $display("Sent %0d samples, checked %0d results, %0d dropped with the store full",
             n_sent, n_checked, n_rej);
    if (errors == 0 && median_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
